/* rtl/macp_pkg.sv */
// Package for the MAC address text parser.
// Holds parser state, character class and result types plus character, byte count and fill constants.
// No dependencies.
package macp_pkg;

  // Character codes of interest
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Byte count limits
  localparam logic [3:0] CNT_SIX   = 4'd6;
  localparam logic [3:0] CNT_EIGHT = 4'd8;

  // Insert bytes for EUI-48 to EUI-64 widening
  localparam logic [15:0] EUI_FILL = 16'hFFFE;

  // Separator kinds
  typedef enum logic [1:0] {
    SEP_NONE  = 2'd0,
    SEP_COLON = 2'd1,
    SEP_DASH  = 2'd2,
    SEP_DOT   = 2'd3
  } sep_t;

  // Parser phases, one-hot
  typedef enum logic [4:0] {
    PH_LEAD   = 5'b00001,
    PH_SECOND = 5'b00010,
    PH_AFTER  = 5'b00100,
    PH_FIRST  = 5'b01000,
    PH_TRAIL  = 5'b10000
  } phase_t;

  // Character classification
  typedef struct packed {
    logic       is_ws;
    logic       is_hex;
    logic [3:0] nibble;
    sep_t       sep;
  } char_class_t;

  // Parser state carried between items
  typedef struct packed {
    phase_t      phase;
    logic [3:0]  byte_count;
    logic [3:0]  pend_nibble;
    logic        pend_bad;
    logic [63:0] addr_bytes;
    sep_t        sep_kind;
    logic        failed;
  } parse_state_t;

  // One result item
  typedef struct packed {
    logic        ok;
    logic [63:0] address;
    logic        from_six_bytes;
  } parse_result_t;

  localparam parse_state_t ST_RESET = '{
    phase:       PH_LEAD,
    byte_count:  4'd0,
    pend_nibble: 4'd0,
    pend_bad:    1'b0,
    addr_bytes:  64'd0,
    sep_kind:    SEP_NONE,
    failed:      1'b0
  };

endpackage

/* rtl/macp_classify.sv */
// Character classifier: whitespace, hex digit value and separator kind.
// Depends on macp_pkg.
module macp_classify
  import macp_pkg::*;
(
  input  logic [7:0]  ch,
  output char_class_t cls
);

  always_comb begin
    cls = '{is_ws: 1'b0, is_hex: 1'b0, nibble: 4'd0, sep: SEP_NONE};

    // space, tab, LF, VT, FF, CR
    cls.is_ws = (ch == CH_SPACE) || (ch inside {[8'h09:8'h0D]});

    // hex digit in either case
    if (ch inside {["0":"9"]}) begin
      cls.is_hex = 1'b1;
      cls.nibble = ch[3:0];
    end else if (ch inside {["A":"F"], ["a":"f"]}) begin
      cls.is_hex = 1'b1;
      cls.nibble = ch[3:0] + 4'd9;
    end

    // separators
    case (ch)
      CH_COLON: cls.sep = SEP_COLON;
      CH_DASH:  cls.sep = SEP_DASH;
      CH_DOT:   cls.sep = SEP_DOT;
      default:  cls.sep = SEP_NONE;
    endcase
  end

endmodule

/* rtl/macp_step.sv */
// Next-state and result logic for one item of the MAC address parser.
// Depends on macp_pkg.
module macp_step
  import macp_pkg::*;
(
  input  parse_state_t  st,
  input  logic          op_end,
  input  char_class_t   cls,
  output parse_state_t  st_nxt,
  output parse_result_t res
);

  logic six_or_eight;

  assign six_or_eight = (st.byte_count == CNT_SIX) || (st.byte_count == CNT_EIGHT);

  // Result seen on an end item
  always_comb begin
    res.ok             = !st.failed && six_or_eight;
    res.from_six_bytes = res.ok && (st.byte_count == CNT_SIX);
    res.address        = 64'd0;
    if (res.from_six_bytes) begin
      res.address = {st.addr_bytes[47:24], EUI_FILL, st.addr_bytes[23:0]};
    end else if (res.ok) begin
      res.address = st.addr_bytes;
    end
  end

  // State update
  always_comb begin
    st_nxt = st;
    if (op_end) begin
      st_nxt = ST_RESET;
    end else if (!st.failed) begin
      case (st.phase)
        PH_LEAD: begin
          if (!cls.is_ws) begin
            st_nxt.phase       = PH_SECOND;
            st_nxt.pend_nibble = cls.nibble;
            st_nxt.pend_bad    = !cls.is_hex;
          end
        end
        PH_SECOND: begin
          if ((st.byte_count >= CNT_EIGHT) || st.pend_bad || !cls.is_hex) begin
            st_nxt.failed = 1'b1;
          end else begin
            st_nxt.byte_count = st.byte_count + 4'd1;
            st_nxt.addr_bytes = {st.addr_bytes[55:0], st.pend_nibble, cls.nibble};
            st_nxt.phase      = PH_AFTER;
          end
        end
        PH_AFTER: begin
          if (cls.sep != SEP_NONE) begin
            if (st.sep_kind == SEP_NONE) begin
              st_nxt.sep_kind = cls.sep;
              st_nxt.phase    = PH_FIRST;
            end else if (st.sep_kind != cls.sep) begin
              st_nxt.failed = 1'b1;
            end else begin
              st_nxt.phase = PH_FIRST;
            end
          end else if (six_or_eight && cls.is_ws) begin
            st_nxt.phase = PH_TRAIL;
          end else begin
            st_nxt.phase       = PH_SECOND;
            st_nxt.pend_nibble = cls.nibble;
            st_nxt.pend_bad    = !cls.is_hex;
          end
        end
        PH_FIRST: begin
          if (six_or_eight && cls.is_ws) begin
            st_nxt.phase = PH_TRAIL;
          end else begin
            st_nxt.phase       = PH_SECOND;
            st_nxt.pend_nibble = cls.nibble;
            st_nxt.pend_bad    = !cls.is_hex;
          end
        end
        PH_TRAIL: begin
          if (!cls.is_ws) begin
            st_nxt.failed = 1'b1;
          end
        end
        default: begin
          st_nxt = st;
        end
      endcase
    end
  end

endmodule

/* rtl/mac_address_text_parser.sv */
// Top level of the MAC address text parser (EUI-48 / EUI-64).
// Depends on macp_pkg, macp_classify and macp_step.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   input   | in_valid, in_ready, in_op, in_ch       | in
//   result  | out_valid, out_ready, out_ok,          | out
//           | out_address, out_from_six_bytes        |
//
// One item per cycle sustained: each item is held in the input register,
// then the classifier and step logic update the parser state from it.
// An end item also loads the output register, which holds its result valid until
// taken. Input stalls only when an end item waits on a full output register.
// Synchronous active-low reset returns the parser to the leading whitespace phase.
module mac_address_text_parser
  import macp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [63:0] out_address,
  output logic        out_from_six_bytes
);

  logic          s1_vld_r;
  logic          s1_op_r;
  logic [7:0]    s1_ch_r;
  parse_state_t  st_r;
  parse_state_t  st_nxt;
  parse_result_t res;
  parse_result_t out_r;
  logic          out_vld_r;
  char_class_t   cls;
  logic          out_free;
  logic          s1_go;

  // Handshake control
  assign out_free = !out_vld_r || out_ready;
  assign s1_go    = s1_vld_r && (!s1_op_r || out_free);
  assign in_ready = !s1_vld_r || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r <= in_op;
      s1_ch_r <= in_ch;
    end
  end

  macp_classify u_classify (
    .ch  (s1_ch_r),
    .cls (cls)
  );

  macp_step u_step (
    .st     (st_r),
    .op_end (s1_op_r),
    .cls    (cls),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (s1_go) begin
      st_r <= st_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_go && s1_op_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_op_r) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_ok             = out_r.ok;
  assign out_address        = out_r.address;
  assign out_from_six_bytes = out_r.from_six_bytes;

endmodule

/* sim/macp_result_checker.sv */
// Result checker for the MAC address text parser, with a small package of test codes.
// It watches both channels, predicts each result and compares it with what comes out.
// Depends on macp_pkg.
package macp_tb_pkg;

  // Item operations
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Control whitespace range: tab through carriage return
  localparam logic [7:0] WS_LO = 8'h09;
  localparam logic [7:0] WS_HI = 8'h0D;

endpackage

module macp_result_checker
  import macp_pkg::*;
  import macp_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_ch,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_ok,
  input  logic [63:0] out_address,
  input  logic        out_from_six_bytes,
  output int          fail_count,
  output int          results_waiting,
  output int          results_seen,
  output int          ok_seen,
  output int          six_seen
);

  localparam int         REPORT_LIMIT = 10;
  localparam logic [4:0] HEX_NONE     = 5'h10;

  // Predicted parser state
  phase_t      ph;
  logic [3:0]  nbytes;
  logic [3:0]  pend_nib;
  logic        pend_bad;
  logic [63:0] addr_acc;
  sep_t        sep_seen;
  logic        failed;

  // Addresses predicted for end items, oldest first
  parse_result_t addr_results_q[$];
  parse_result_t got, want;
  int            mismatches;
  int            strings_done;
  int            oks, sixes;

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= WS_LO && c <= WS_HI);
  endfunction

  // Nibble value, or HEX_NONE for anything that is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      return {1'b0, c[3:0] + 4'd9};
    return HEX_NONE;
  endfunction

  function automatic sep_t sep_of(input logic [7:0] c);
    case (c)
      CH_COLON: return SEP_COLON;
      CH_DASH:  return SEP_DASH;
      CH_DOT:   return SEP_DOT;
      default:  return SEP_NONE;
    endcase
  endfunction

  function automatic logic six_or_eight();
    return nbytes == CNT_SIX || nbytes == CNT_EIGHT;
  endfunction

  task automatic clear_parser();
    ph       = PH_LEAD;
    nbytes   = '0;
    pend_nib = '0;
    pend_bad = 1'b0;
    addr_acc = '0;
    sep_seen = SEP_NONE;
    failed   = 1'b0;
  endtask

  // First character of a pair: a bad one is only caught when the pair completes
  task automatic take_first(input logic [7:0] c);
    logic [4:0] v;
    v        = hex_value(c);
    pend_bad = v[4];
    pend_nib = v[3:0];
    ph       = PH_SECOND;
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic [4:0] v;
    sep_t       s;
    v = hex_value(c);
    s = sep_of(c);
    if (failed) return;
    case (ph)
      PH_LEAD: begin
        if (!is_space(c)) take_first(c);
      end
      PH_SECOND: begin
        if (nbytes >= CNT_EIGHT || pend_bad || v[4]) begin
          failed = 1'b1;
        end else begin
          nbytes   = nbytes + 4'd1;
          addr_acc = {addr_acc[55:0], pend_nib, v[3:0]};
          ph       = PH_AFTER;
        end
      end
      PH_AFTER: begin
        if (s != SEP_NONE) begin
          // only one separator kind per string
          if (sep_seen != SEP_NONE && sep_seen != s) begin
            failed = 1'b1;
          end else begin
            sep_seen = s;
            ph       = PH_FIRST;
          end
        end else if (six_or_eight() && is_space(c)) begin
          ph = PH_TRAIL;
        end else begin
          take_first(c);
        end
      end
      PH_FIRST: begin
        if (six_or_eight() && is_space(c)) ph = PH_TRAIL;
        else take_first(c);
      end
      default: begin
        if (!is_space(c)) failed = 1'b1;
      end
    endcase
  endtask

  // Result of an end item; six bytes widen to EUI-64 around FF FE
  function automatic parse_result_t finish_string();
    parse_result_t r;
    r = '0;
    if (!failed && six_or_eight()) begin
      r.ok = 1'b1;
      if (nbytes == CNT_SIX) begin
        r.from_six_bytes = 1'b1;
        r.address        = {addr_acc[47:24], EUI_FILL, addr_acc[23:0]};
      end else begin
        r.address = addr_acc;
      end
    end
    return r;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      addr_results_q.delete();
      mismatches   = 0;
      strings_done = 0;
      oks          = 0;
      sixes        = 0;
    end else begin
      // results first: an end item cannot produce its result in the same cycle
      if (out_valid && out_ready) begin
        got.ok             = out_ok;
        got.address        = out_address;
        got.from_six_bytes = out_from_six_bytes;
        strings_done++;
        if (addr_results_q.size() == 0) begin
          note_failure($sformatf("unexpected result ok=%0b address=%016h six=%0b",
                                 got.ok, got.address, got.from_six_bytes));
        end else begin
          want = addr_results_q.pop_front();
          if (got.ok !== want.ok || got.address !== want.address ||
              got.from_six_bytes !== want.from_six_bytes)
            note_failure($sformatf(
              "string %0d: expected ok=%0b address=%016h six=%0b, got ok=%0b address=%016h six=%0b",
              strings_done, want.ok, want.address, want.from_six_bytes,
              got.ok, got.address, got.from_six_bytes));
          if (want.ok) oks++;
          if (want.from_six_bytes) sixes++;
        end
      end
      if (in_valid && in_ready) begin
        if (in_op == OP_END) begin
          addr_results_q.push_back(finish_string());
          clear_parser();
        end else begin
          parse_char(in_ch);
        end
      end
    end
    fail_count      <= mismatches;
    results_waiting <= addr_results_q.size();
    results_seen    <= strings_done;
    ok_seen         <= oks;
    six_seen        <= sixes;
  end

endmodule

/* sim/mac_address_text_parser_tb.sv */
// Testbench top for the MAC address text parser: clock, reset, character stimulus,
// receiver back-pressure, watchdog and verdict. Depends on macp_pkg, macp_tb_pkg,
// macp_result_checker and the parser RTL.
module mac_address_text_parser_tb;
  import macp_pkg::*;
  import macp_tb_pkg::*;

  localparam int ITEMS_PER_PASS = 640;
  localparam int HOLD_CYCLES    = 300;
  localparam int STALL_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 8;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_op     = OP_CHAR;
  logic [7:0]  in_ch     = 8'h00;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ok;
  logic [63:0] out_address;
  logic        out_from_six_bytes;

  int fail_count, results_waiting, results_seen, ok_seen, six_seen;
  int items_sent   = 0;
  int send_idle    = 0;
  int recv_idle    = 0;
  int hold_reqs    = 0;
  int holds_done   = 0;
  int stall_cycles = 0;

  // Characters of the string being built
  logic [7:0] text_q[$];

  mac_address_text_parser u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_ch              (in_ch),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ok             (out_ok),
    .out_address        (out_address),
    .out_from_six_bytes (out_from_six_bytes)
  );

  macp_result_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_ch              (in_ch),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ok             (out_ok),
    .out_address        (out_address),
    .out_from_six_bytes (out_from_six_bytes),
    .fail_count         (fail_count),
    .results_waiting    (results_waiting),
    .results_seen       (results_seen),
    .ok_seen            (ok_seen),
    .six_seen           (six_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random ready, plus a long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog on cycles where neither channel moves an item
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("mac_address_text_parser verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Called and returns at a falling edge; valid stays high between back-to-back items
  task automatic send_item(input logic op, input logic [7:0] c);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_ch    <= c;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Characters of the queued string, then the end item with a don't-care code
  task automatic send_text();
    foreach (text_q[i]) send_item(OP_CHAR, text_q[i]);
    send_item(OP_END, 8'($urandom_range(255)));
    text_q.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] random_space();
    int unsigned r;
    r = $urandom_range(5);
    return (r == 5) ? CH_SPACE : WS_LO + 8'(r);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] sep_char(input int unsigned k);
    case (k % 3)
      0:       return CH_COLON;
      1:       return CH_DASH;
      default: return CH_DOT;
    endcase
  endfunction

  // Mostly well-formed addresses; some with odd byte counts, stray separators,
  // trailing junk, or one character overwritten with a random code
  task automatic build_address();
    int unsigned kind, nbytes, sep_k, r;
    logic        use_sep;
    kind    = $urandom_range(99);
    nbytes  = (kind < 75) ? ($urandom_range(1) ? 6 : 8) : $urandom_range(10);
    use_sep = $urandom_range(3) != 0;
    sep_k   = $urandom_range(2);
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) text_q.push_back(random_space());
    for (int i = 0; i < nbytes; i++) begin
      text_q.push_back(hex_char(4'($urandom_range(15))));
      text_q.push_back(hex_char(4'($urandom_range(15))));
      if (use_sep && (i < nbytes - 1 || $urandom_range(3) == 0) && $urandom_range(9) != 0) begin
        r = $urandom_range(39);
        if (r == 0) begin
          text_q.push_back(sep_char(sep_k + $urandom_range(1, 2)));
        end else if (r == 1) begin
          text_q.push_back(sep_char(sep_k));
          text_q.push_back(sep_char(sep_k));
        end else begin
          text_q.push_back(sep_char(sep_k));
        end
      end
    end
    // trailing whitespace, sometimes followed by text
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(1, 3)) text_q.push_back(random_space());
      if ($urandom_range(7) == 0) text_q.push_back(8'($urandom_range(1, 255)));
    end
    if ($urandom_range(9) == 0) text_q.push_back(8'($urandom_range(1, 255)));
    if (kind >= 88 && text_q.size() > 0)
      text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(1, 255));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0:       begin send_idle = 34; recv_idle = 84; end
        1:       begin send_idle = 84; recv_idle = 34; end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase

      if (pass == 0) begin
        // empty string
        send_text();
        // leading whitespace, then a lone trailing character
        add_text(" \tF");
        send_text();
        // bad pair built from extreme codes
        text_q.push_back(8'hFF);
        text_q.push_back(8'h01);
        send_text();
        // separator change as the last character
        add_text("0f:1a-");
        send_text();
        // doubled separator
        add_text("Aa..0");
        send_text();
        // code zero is just another bad character
        text_q.push_back(8'h00);
        add_text("0");
        send_text();
      end

      // output held off while strings keep coming: input must stall
      if (pass == 2) hold_reqs++;

      while (items_sent < (pass + 1) * ITEMS_PER_PASS) begin
        build_address();
        send_text();
      end
    end
    in_valid <= 1'b0;

    wait (results_waiting == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d items making %0d strings: %0d valid, %0d widened from six bytes.",
             items_sent, results_seen, ok_seen, six_seen);
    $display("Idle mixes on both sides, a free-running stretch and a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (fail_count == 0 && results_waiting == 0) begin
      $display("mac_address_text_parser verification clean");
    end else begin
      $display("mac_address_text_parser verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/macp_pkg.sv
rtl/macp_classify.sv
rtl/macp_step.sv
rtl/mac_address_text_parser.sv
sim/macp_result_checker.sv
sim/mac_address_text_parser_tb.sv
